/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the substring search unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Condition holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif

`endif

/* rtl/core/ssfis_pkg.sv */
// Shared types and constants of the substring search unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssfis_pkg;

   localparam int LEN_W     = 5;   // pattern length register width
   localparam int PAT_BYTES = 16;  // bytes held by the two pattern registers
   localparam int PAT_IDX_W = 4;
   localparam int CNT_W     = 16;  // buffer byte count / match position
   localparam int Q_DEPTH   = 4;   // front-to-back queue depth
   localparam int Q_PTR_W   = 2;
   localparam int Q_LVL_W   = 3;

   // Configuration register indexes
   localparam logic [1:0] CSR_PAT_LO = 2'd0;
   localparam logic [1:0] CSR_PAT_HI = 2'd1;
   localparam logic [1:0] CSR_PAT_LEN = 2'd2;

   typedef enum logic [1:0] {
      ST_FOUND = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   // What an accepted word asks of the back end
   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_LAST      = 2'd1,
      KIND_BYTE_LAST = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic               head_valid;
      logic               full;
      logic [Q_LVL_W-1:0] level;
   } q_status_type;

endpackage

/* rtl/core/ssfis_front.sv */
// Front end: accepts request words, classifies them, feeds the queue.
// Depends on ssfis_pkg.
`timescale 1ns / 1ps

module ssfis_front import ssfis_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_has_byte,
   input  logic         req_last_item,
   input  q_status_type q_status,
   output logic         push_valid,
   output item_type     push_item
);

   logic     front_valid_ff, front_valid_in;
   item_type item_ff, item_in;
   logic     accept, keep;

   assign req_ready = !front_valid_ff || !q_status.full;
   assign accept    = req_valid && req_ready;
   // a word with no byte and no end mark changes nothing: drop it here
   assign keep      = req_has_byte || req_last_item;

   always_comb begin
      item_in.data = req_data_byte;
      if (req_has_byte && req_last_item) begin
         item_in.kind = KIND_BYTE_LAST;
      end else if (req_last_item) begin
         item_in.kind = KIND_LAST;
      end else begin
         item_in.kind = KIND_BYTE;
      end
   end

   assign front_valid_in = (accept && keep) || (front_valid_ff && q_status.full);
   assign push_valid     = front_valid_ff && !q_status.full;
   assign push_item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/core/ssfis_queue.sv */
// Short queue that decouples the front end from the search back end.
// Depends on ssfis_pkg.
`timescale 1ns / 1ps

module ssfis_queue import ssfis_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  item_type     push_item,
   input  logic         pop,
   output item_type     head_item,
   output q_status_type q_status
);

   item_type           entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_LVL_W-1:0] level_ff, level_in;
   logic               do_push, do_pop;

   assign do_push = push_valid && (level_ff != Q_LVL_W'(Q_DEPTH));
   assign do_pop  = pop && (level_ff != '0);

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item           = entry_ff[rd_ptr_ff];
   assign q_status.head_valid = (level_ff != '0);
   assign q_status.full       = (level_ff == Q_LVL_W'(Q_DEPTH));
   assign q_status.level      = level_ff;

endmodule

/* rtl/core/ssfis_back.sv */
// Back end: byte window, parallel pattern compare, result register.
// Depends on ssfis_pkg.
`timescale 1ns / 1ps

module ssfis_back import ssfis_pkg::*; #(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_BUFFER  = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      pattern_lo,
   input  logic [63:0]      pattern_hi,
   input  logic [LEN_W-1:0] pattern_len,
   input  q_status_type     q_status,
   input  item_type         head_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_match_index
);

   logic [7:0]       win_ff [MAX_PATTERN];
   logic [7:0]       win_in [MAX_PATTERN];
   logic [7:0]       pat [PAT_BYTES];
   logic [CNT_W-1:0] count_ff, count_in, count_new;
   logic [CNT_W-1:0] pos_ff, pos_in, pos_new;
   logic             seen_ff, seen_in, seen_new;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [CNT_W-1:0] index_ff, index_in;
   logic [LEN_W-1:0] used_len, sel;
   logic             has_byte, is_last, take, all_eq, hit;

   always_comb begin
      unique case (head_item.kind) inside
         KIND_BYTE:      begin has_byte = 1'b1; is_last = 1'b0; end
         KIND_LAST:      begin has_byte = 1'b0; is_last = 1'b1; end
         KIND_BYTE_LAST: begin has_byte = 1'b1; is_last = 1'b1; end
         default:        begin has_byte = 1'b0; is_last = 1'b0; end
      endcase
   end

   // a result word needs the output register free
   assign pop = q_status.head_valid && (!is_last || !rsp_valid_ff || rsp_ready);

   always_comb begin
      if (pattern_len == '0) begin
         used_len = LEN_W'(1);
      end else if (pattern_len > LEN_W'(MAX_PATTERN)) begin
         used_len = LEN_W'(MAX_PATTERN);
      end else begin
         used_len = pattern_len;
      end
   end

   always_comb begin
      for (int k = 0; k < PAT_BYTES; k++) begin
         if (k < 8) begin
            pat[k] = pattern_lo[8*k +: 8];
         end else begin
            pat[k] = pattern_hi[8*(k-8) +: 8];
         end
      end
   end

   // bytes past the bound are dropped without touching the window
   assign take      = has_byte && (count_ff < CNT_W'(MAX_BUFFER));
   assign count_new = take ? count_ff + 1'b1 : count_ff;

   always_comb begin
      win_in[0] = take ? head_item.data : win_ff[0];
      for (int i = 1; i < MAX_PATTERN; i++) begin
         win_in[i] = take ? win_ff[i-1] : win_ff[i];
      end
   end

   // window entry j (0 newest) lines up with pattern byte used_len-1-j
   always_comb begin
      all_eq = 1'b1;
      sel    = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         sel = used_len - LEN_W'(1) - LEN_W'(j);
         if ((LEN_W'(j) < used_len) && (win_in[j] != pat[sel[PAT_IDX_W-1:0]])) begin
            all_eq = 1'b0;
         end
      end
   end

   assign hit      = take && !seen_ff && (count_new >= CNT_W'(used_len)) && all_eq;
   assign seen_new = seen_ff || hit;
   assign pos_new  = hit ? count_new - CNT_W'(used_len) : pos_ff;

   always_comb begin
      count_in     = count_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         count_in = count_new;
         seen_in  = seen_new;
         pos_in   = pos_new;
         if (is_last) begin
            rsp_valid_in = 1'b1;
            index_in     = '0;
            if (count_new == '0) begin
               status_in = ST_EMPTY;
            end else if (count_new < CNT_W'(used_len)) begin
               status_in = ST_SHORT;
            end else if (seen_new) begin
               status_in = ST_FOUND;
               index_in  = pos_new;
            end else begin
               status_in = ST_NONE;
            end
            count_in = '0;
            seen_in  = 1'b0;
            pos_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      index_ff  <= index_in;
      if (pop) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_match_index = index_ff;

endmodule

/* rtl/core/substring_first_index_search_unit.sv */
// Top level of the streaming first-match substring search unit.
// Depends on ssfis_pkg, ssfis_front, ssfis_queue, ssfis_back, assert_macros.svh.
//
// Usage:
//  - req_ channel: one buffer byte per word (req_data_byte valid when
//    req_has_byte), req_last_item closes the buffer. A word with neither
//    flag set is accepted and has no effect.
//  - rsp_ channel: one word per closed buffer, rsp_status (found, empty,
//    shorter than pattern, not found) and rsp_match_index (zero unless found).
//  - csr_ channel: pattern bytes 0-7, 8-15 and the pattern length, written
//    while the unit is idle; csr_ready is always high.
//  - Throughput: one word per cycle while no result is held. The window compare is fully
//    parallel over MAX_PATTERN bytes, so each byte retires as the back end pops it.
//  - Path: a closing word passes the front register, a queue entry and then
//    the back end's result register before it shows on rsp_.
//  - Stall: a held result blocks a closing word at the queue head and all words
//    behind it; byte words ahead keep flowing, and the four-deep queue plus front
//    register absorb the rest before req_ready drops.
//  - Reset: pattern cleared, length 1, stream state and queue empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module substring_first_index_search_unit import ssfis_pkg::*; #(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_BUFFER  = 65535
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_data_byte,
   input  logic             req_has_byte,
   input  logic             req_last_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [CNT_W-1:0] rsp_match_index,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);

   // configuration registers
   logic [63:0]      pat_lo_ff, pat_hi_ff;
   logic [LEN_W-1:0] pat_len_ff;
   logic             csr_write;

   // front to queue, queue to back
   q_status_type q_status;
   logic         push_valid, pop;
   item_type     push_item, head_item;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= LEN_W'(1);
      end else if (csr_write) begin
         // an index past the list is ignored
         case (csr_index)
            CSR_PAT_LO:  pat_lo_ff  <= csr_wdata;
            CSR_PAT_HI:  pat_hi_ff  <= csr_wdata;
            CSR_PAT_LEN: pat_len_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   ssfis_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_has_byte  (req_has_byte),
      .req_last_item (req_last_item),
      .q_status      (q_status),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   ssfis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .q_status   (q_status)
   );

   ssfis_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_BUFFER  (MAX_BUFFER)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pattern_lo      (pat_lo_ff),
      .pattern_hi      (pat_hi_ff),
      .pattern_len     (pat_len_ff),
      .q_status        (q_status),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_match_index (rsp_match_index)
   );

   // index carries a position only with a found status
   `ASSERT_IMPLIES(a_index_zero, clock, reset,
      rsp_valid && (rsp_status != ST_FOUND), rsp_match_index == '0)
   // queue never overfills
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, q_status.level <= Q_LVL_W'(Q_DEPTH))
   // a length write lands in the register
   `ASSERT_NEXT(a_len_write, clock, reset,
      csr_write && (csr_index == CSR_PAT_LEN), pat_len_ff == $past(csr_wdata[LEN_W-1:0]))

endmodule
